@@ src/cse_pkg.sv @@
// Package: shared types, character codes and the escape classifier.
`timescale 1ns / 1ps
package cse_pkg;

  localparam int PREFIX_MAX = 8;
  localparam int QDEPTH     = 4;

  // configuration register indexes
  localparam logic [2:0] REG_TEXT_WIDTH    = 3'd0;
  localparam logic [2:0] REG_TAB_COLS      = 3'd1;
  localparam logic [2:0] REG_PREFIX_BYTES  = 3'd2;
  localparam logic [2:0] REG_PREFIX_COUNT  = 3'd3;
  localparam logic [2:0] REG_ESCAPE_TABS   = 3'd4;
  localparam logic [2:0] REG_BREAK_ON_NL   = 3'd5;

  localparam logic [7:0] TEXT_WIDTH_RST = 8'd69;
  localparam logic [4:0] TAB_COLS_RST   = 5'd8;

  // character codes
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_LE    = 8'h65;
  localparam logic [7:0] CH_LF_A  = 8'h66;
  localparam logic [7:0] CH_LN    = 8'h6E;
  localparam logic [7:0] CH_LR    = 8'h72;
  localparam logic [7:0] CH_LT    = 8'h74;
  localparam logic [7:0] CH_LV    = 8'h76;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] HEX_ALPHA_BASE = 8'h57; // 'a' - 10

  typedef struct packed {
    logic [7:0]  text_width;
    logic [4:0]  tab_cols;
    logic [63:0] prefix_bytes;
    logic [3:0]  prefix_count;
    logic        escape_tabs;
    logic        break_on_newline;
  } cfg_t;

  // one escaped piece of text, chars[0] goes out first
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [2:0]      len;
    logic            is_tab;
    logic            is_lf;
    logic            is_final;
    logic            item_end;
  } piece_t;

  typedef struct packed {
    logic [1:0] cnt;
    piece_t     a;
    piece_t     b;
  } push_t;

  typedef enum logic [2:0] {
    PH_START,
    PH_CLOSE_Q,
    PH_CLOSE_NL,
    PH_PREFIX,
    PH_OPEN_Q,
    PH_BODY,
    PH_END_Q,
    PH_END_NL
  } phase_t;

  function automatic logic is_dec(logic [7:0] d);
    return (d >= CH_ZERO) && (d <= CH_NINE);
  endfunction

  function automatic logic is_hex(logic [7:0] d);
    return is_dec(d) || ((d >= CH_LA) && (d <= CH_LF_A)) || ((d >= CH_UA) && (d <= CH_UF));
  endfunction

  function automatic logic [7:0] hex_digit(logic [3:0] v);
    return (v >= 4'd10) ? (HEX_ALPHA_BASE + {4'b0, v}) : (CH_ZERO + {4'b0, v});
  endfunction

  function automatic piece_t esc_piece(logic [7:0] c, logic la_ok, logic [7:0] la,
                                       logic esc_tab);
    piece_t p;
    logic   unpr;
    p          = '0;
    p.chars[0] = CH_BSL;
    p.len      = 3'd2;
    unpr       = 1'b0;
    case (c)
      CH_CR:    p.chars[1] = CH_LR;
      CH_LF:    begin
        p.chars[1] = CH_LN;
        p.is_lf    = 1'b1;
      end
      CH_QUOTE: p.chars[1] = CH_QUOTE;
      CH_QMARK: p.chars[1] = CH_QMARK;
      CH_BSL:   p.chars[1] = CH_BSL;
      CH_BEL:   p.chars[1] = CH_LA;
      CH_BS:    p.chars[1] = CH_LB;
      CH_ESC:   p.chars[1] = CH_LE;
      CH_FF:    p.chars[1] = CH_LF_A;
      CH_VT:    p.chars[1] = CH_LV;
      CH_TAB:   begin
        if (esc_tab) begin
          p.chars[1] = CH_LT;
        end else begin
          p.chars[0] = CH_TAB;
          p.len      = 3'd1;
          p.is_tab   = 1'b1;
        end
      end
      default: begin
        if ((c >= CH_SPACE) && (c <= CH_TILDE)) begin
          p.chars[0] = c;
          p.len      = 3'd1;
        end else begin
          unpr = 1'b1;
        end
      end
    endcase
    if (unpr) begin
      if ((c == 8'd0) && !(la_ok && is_dec(la))) begin
        p.chars[1] = CH_ZERO;
      end else if (!(la_ok && is_hex(la))) begin
        p.len      = 3'd4;
        p.chars[1] = CH_LX;
        p.chars[2] = hex_digit(c[7:4]);
        p.chars[3] = hex_digit(c[3:0]);
      end else begin
        // octal keeps a following hex digit out of the escape
        p.len      = 3'd4;
        p.chars[1] = CH_ZERO + {6'b0, c[7:6]};
        p.chars[2] = CH_ZERO + {5'b0, c[5:3]};
        p.chars[3] = CH_ZERO + {5'b0, c[2:0]};
      end
    end
    return p;
  endfunction

endpackage

@@ src/cse_front.sv @@
// Front end: holds one byte for lookahead and turns input words into pieces.
`timescale 1ns / 1ps
module cse_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_data_byte,
  input  logic           in_is_final,
  input  logic           escape_tabs,
  input  logic           q_room2,
  output cse_pkg::push_t push
);
  import cse_pkg::*;

  logic [7:0] held_byte_r, held_byte_nxt;
  logic       held_valid_r, held_valid_nxt;
  logic       acc;
  piece_t     p_held, p_fin;

  assign in_ready = q_room2;
  assign acc      = in_valid && in_ready;

  always_comb begin
    p_held          = esc_piece(held_byte_r, 1'b1, in_data_byte, escape_tabs);
    p_fin           = esc_piece(in_data_byte, 1'b0, 8'd0, escape_tabs);
    p_fin.is_final  = 1'b1;
    p_fin.item_end  = 1'b1;
    p_held.item_end = !in_is_final;
    push.cnt        = 2'd0;
    push.a          = p_held;
    push.b          = p_fin;
    if (acc) begin
      if (held_valid_r) begin
        push.cnt = in_is_final ? 2'd2 : 2'd1;
      end else if (in_is_final) begin
        push.cnt = 2'd1;
        push.a   = p_fin;
      end
    end
  end

  always_comb begin
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    if (acc) begin
      held_byte_nxt  = in_is_final ? 8'd0 : in_data_byte;
      held_valid_nxt = !in_is_final;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_byte_r  <= 8'd0;
      held_valid_r <= 1'b0;
    end else begin
      held_byte_r  <= held_byte_nxt;
      held_valid_r <= held_valid_nxt;
    end
  end

endmodule

@@ src/cse_queue.sv @@
// Piece queue between front and back: up to two writes and one read per cycle.
`timescale 1ns / 1ps
module cse_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  cse_pkg::push_t  push,
  input  logic            pop,
  output cse_pkg::piece_t head,
  output logic            head_valid,
  output logic            room2
);
  import cse_pkg::*;

  localparam int AW = $clog2(QDEPTH);

  piece_t        mem_r [QDEPTH];
  logic [AW-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [AW:0]   count_r, count_nxt;
  logic [AW-1:0] wptr_p1;

  assign wptr_p1    = wptr_r + AW'(1);
  assign head       = mem_r[rptr_r];
  assign head_valid = count_r != '0;
  assign room2      = count_r <= (AW+1)'(QDEPTH - 2);

  always_comb begin
    wptr_nxt  = wptr_r + AW'(push.cnt);
    rptr_nxt  = pop ? rptr_r + AW'(1) : rptr_r;
    count_nxt = count_r + (AW+1)'(push.cnt) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wptr_r] <= push.a;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wptr_p1] <= push.b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0) else $error("queue pop while empty");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> room2) else $error("queue push without room");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (AW+1)'(QDEPTH)) else $error("queue count overflow");

endmodule

@@ src/cse_back.sv @@
// Back end: line wrapping sequencer emitting one character per cycle unless the output stalls or the queue is empty.
`timescale 1ns / 1ps
module cse_back (
  input  logic            clk,
  input  logic            rst_n,
  input  cse_pkg::cfg_t   cfg,
  input  cse_pkg::piece_t head,
  input  logic            head_valid,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_char,
  output logic            out_run_end
);
  import cse_pkg::*;

  phase_t     ph_r, ph_nxt, cur_ph;
  logic [2:0] idx_r, idx_nxt;
  logic       line_open_r, line_open_nxt;
  logic [7:0] fill_r, fill_nxt, limit_r, limit_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r, out_char_nxt;
  logic       run_end_r, run_end_nxt;

  logic [3:0] pfx_len;
  logic [8:0] cost, need;
  logic [8:0] sum9;
  logic       adv, body_last, close_after, done;
  logic [7:0] gen_char;

  assign pfx_len     = (cfg.prefix_count > 4'(PREFIX_MAX)) ? 4'(PREFIX_MAX)
                                                           : cfg.prefix_count;
  assign cost        = head.is_tab ? {4'b0, cfg.tab_cols} : {6'b0, head.len};
  assign need        = {1'b0, fill_r} + cost;
  assign sum9        = {1'b0, fill_r} + {6'b0, head.len};
  assign body_last   = idx_r == (head.len - 3'd1);
  assign close_after = head.is_final || (head.is_lf && cfg.break_on_newline);

  // the start step picks its route in the same cycle as the first character
  always_comb begin
    cur_ph = ph_r;
    if (ph_r == PH_START && head_valid) begin
      if (line_open_r && (need > {1'b0, limit_r})) begin
        cur_ph = PH_CLOSE_Q;
      end else if (!line_open_r) begin
        cur_ph = (pfx_len != 4'd0) ? PH_PREFIX : PH_OPEN_Q;
      end else begin
        cur_ph = PH_BODY;
      end
    end
  end

  assign adv  = (cur_ph != PH_START) && (!out_valid_r || out_ready);
  assign done = ((cur_ph == PH_BODY) && body_last && !close_after) || (cur_ph == PH_END_NL);
  assign pop  = adv && done;

  // next state
  always_comb begin
    ph_nxt        = ph_r;
    idx_nxt       = idx_r;
    line_open_nxt = line_open_r;
    fill_nxt      = fill_r;
    limit_nxt     = limit_r;
    if (adv) begin
      case (cur_ph)
        PH_CLOSE_Q: ph_nxt = PH_CLOSE_NL;
        PH_CLOSE_NL: begin
          ph_nxt        = (pfx_len != 4'd0) ? PH_PREFIX : PH_OPEN_Q;
          idx_nxt       = 3'd0;
          line_open_nxt = 1'b0;
          fill_nxt      = 8'd0;
          limit_nxt     = cfg.text_width;
        end
        PH_PREFIX: begin
          if ({1'b0, idx_r} == (pfx_len - 4'd1)) begin
            ph_nxt  = PH_OPEN_Q;
            idx_nxt = 3'd0;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
        PH_OPEN_Q: begin
          ph_nxt        = PH_BODY;
          idx_nxt       = 3'd0;
          line_open_nxt = 1'b1;
          fill_nxt      = 8'd0;
          limit_nxt     = cfg.text_width;
        end
        PH_BODY: begin
          if (body_last) begin
            ph_nxt   = close_after ? PH_END_Q : PH_START;
            idx_nxt  = 3'd0;
            fill_nxt = sum9[8] ? 8'hFF : sum9[7:0];
            if (head.is_tab) begin
              limit_nxt = (limit_r > {3'b0, cfg.tab_cols}) ? limit_r - {3'b0, cfg.tab_cols}
                                                           : 8'd0;
            end
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
        PH_END_Q: ph_nxt = PH_END_NL;
        PH_END_NL: begin
          ph_nxt        = PH_START;
          line_open_nxt = 1'b0;
          fill_nxt      = 8'd0;
          limit_nxt     = cfg.text_width;
        end
        default: ph_nxt = PH_START;
      endcase
    end
  end

  // outputs
  always_comb begin
    case (cur_ph)
      PH_CLOSE_Q, PH_OPEN_Q, PH_END_Q: gen_char = CH_QUOTE;
      PH_CLOSE_NL, PH_END_NL:          gen_char = CH_LF;
      PH_PREFIX:                       gen_char = cfg.prefix_bytes[{idx_r, 3'b000} +: 8];
      PH_BODY:                         gen_char = head.chars[idx_r[1:0]];
      default:                         gen_char = 8'd0;
    endcase
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    run_end_nxt   = run_end_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = gen_char;
      run_end_nxt   = done && head.item_end;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_char    = out_char_r;
  assign out_run_end = run_end_r;

  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    run_end_r  <= run_end_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= PH_START;
      idx_r       <= 3'd0;
      line_open_r <= 1'b0;
      fill_r      <= 8'd0;
      limit_r     <= TEXT_WIDTH_RST;
      out_valid_r <= 1'b0;
    end else begin
      ph_r        <= ph_nxt;
      idx_r       <= idx_nxt;
      line_open_r <= line_open_nxt;
      fill_r      <= fill_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_body_open: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == PH_BODY) |-> line_open_r) else $error("text emitted outside an open line");
  a_prefix_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_ph == PH_PREFIX) |-> !line_open_r) else $error("prefix inside an open line");
  a_end_open: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == PH_END_Q) |-> line_open_r) else $error("closing quote with no open line");

endmodule

@@ src/c_string_literal_escaper_top.sv @@
// Top level: configuration registers, front end, piece queue and back end.
`timescale 1ns / 1ps
// Turns a byte stream into C string literal lines: prefix, quote, escaped
// text, quote, newline.
// Input channel (in_valid/in_ready): one text byte per word, in_is_final on
// the last byte. A non-final byte is held as lookahead until the next one
// arrives, so its characters come out when the following word is accepted.
// Output channel (out_valid/out_ready): one character per word, out_run_end
// on the last character caused by an input word.
// Config channel (cfg_valid/cfg_ready): always ready; write only while idle.
// Path: an accepted word's pieces are written into the piece queue, the back
// end reads the head piece and registers its first character onto out_valid.
// Throughput: one output character per cycle while out_ready is high and
// pieces wait in the queue; a word causes 0 to 32 characters, paced by the
// single character-per-cycle back end sequencer. A four-entry piece queue
// lets input run ahead; input is taken while two queue entries are free.
// Reset: nothing held, no line open, registers at their defaults.
// Output stall: the output register holds, the queue fills, then in_ready
// drops until the back end drains it.
module c_string_literal_escaper_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_is_final,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic        out_run_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import cse_pkg::*;

  cfg_t   cfg_r, cfg_nxt;
  push_t  push;
  piece_t head;
  logic   head_valid, room2, pop;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TEXT_WIDTH:   cfg_nxt.text_width       = cfg_data[7:0];
        REG_TAB_COLS:     cfg_nxt.tab_cols         = cfg_data[4:0];
        REG_PREFIX_BYTES: cfg_nxt.prefix_bytes     = cfg_data;
        REG_PREFIX_COUNT: cfg_nxt.prefix_count     = cfg_data[3:0];
        REG_ESCAPE_TABS:  cfg_nxt.escape_tabs      = cfg_data[0];
        REG_BREAK_ON_NL:  cfg_nxt.break_on_newline = cfg_data[0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.text_width       <= TEXT_WIDTH_RST;
      cfg_r.tab_cols         <= TAB_COLS_RST;
      cfg_r.prefix_bytes     <= 64'd9;
      cfg_r.prefix_count     <= 4'd1;
      cfg_r.escape_tabs      <= 1'b0;
      cfg_r.break_on_newline <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cse_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_is_final  (in_is_final),
    .escape_tabs  (cfg_r.escape_tabs),
    .q_room2      (room2),
    .push         (push)
  );

  cse_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .room2      (room2)
  );

  cse_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .head        (head),
    .head_valid  (head_valid),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_char    (out_char),
    .out_run_end (out_run_end)
  );

endmodule
